@@ hw/rtl/rect_grid_test_pattern_pixel_macros.svh @@
`ifndef RECT_GRID_TEST_PATTERN_PIXEL_MACROS_SVH
`define RECT_GRID_TEST_PATTERN_PIXEL_MACROS_SVH

// same-cycle implication, off during reset
`define RGTP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgtp check failed");

// next-cycle implication, off during reset
`define RGTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgtp check failed");

`endif

@@ hw/rtl/rgtp_pkg.sv @@
`timescale 1ns / 1ps

package rgtp_pkg;

    // field widths
    localparam int COORD_BITS_DEF  = 12;
    localparam int DIM_BITS        = 13;
    localparam int CNT_BITS        = 8;
    localparam int COLOR_BITS      = 32;
    localparam int COLOR_STEP_BITS = 8;
    localparam int BPP_BITS        = 6;
    localparam int LAYOUT_BITS     = 30;
    localparam int FIELD_BITS      = 5;
    localparam int NUM_CHAN        = 3;
    localparam int ADDR_BITS       = 26;

    // bytes per pixel rounding
    localparam int BITS_PER_BYTE = 8;
    localparam int BPB_ROUND     = BITS_PER_BYTE - 1;
    localparam int BPB_SHIFT     = $clog2(BITS_PER_BYTE);
    localparam int BPB_BITS      = BPP_BITS - BPB_SHIFT + 1;

    // apb register map
    localparam int REG_IDX_BITS = 3;
    localparam int PADDR_BITS   = REG_IDX_BITS + 2;
    localparam int PDATA_BITS   = 32;

    localparam logic [REG_IDX_BITS-1:0] REG_H_RES          = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_V_RES          = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_RECT_COUNT     = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_FIRST_COLOR    = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_COLOR_STEP     = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_DIRECT_MODE    = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_PIX_DEPTH      = 3'd6;
    localparam logic [REG_IDX_BITS-1:0] REG_CHANNEL_LAYOUT = 3'd7;

    // register reset values
    localparam logic [DIM_BITS-1:0]        H_RES_RST      = 13'd640;
    localparam logic [DIM_BITS-1:0]        V_RES_RST      = 13'd480;
    localparam logic [CNT_BITS-1:0]        RECT_COUNT_RST = 8'd1;
    localparam logic [COLOR_BITS-1:0]      FIRST_COLOR_RST = '0;
    localparam logic [COLOR_STEP_BITS-1:0] COLOR_STEP_RST = '0;
    localparam logic                       DIRECT_MODE_RST = 1'b0;
    localparam logic [BPP_BITS-1:0]        BPP_RST        = 6'd8;
    localparam logic [LAYOUT_BITS-1:0]     LAYOUT_RST     = '0;

    // skid queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // settings and derived grid geometry seen by the datapath
    typedef struct packed {
        logic [DIM_BITS-1:0]        h_res;
        logic [CNT_BITS-1:0]        rect_count;
        logic [COLOR_BITS-1:0]      first_color;
        logic [COLOR_STEP_BITS-1:0] color_step;
        logic                       direct_mode;
        logic [BPP_BITS-1:0]        pix_depth;
        logic [LAYOUT_BITS-1:0]     channel_layout;
        logic [DIM_BITS-1:0]        col_width;
        logic [DIM_BITS-1:0]        row_height;
        logic [DIM_BITS-1:0]        col_limit;
        logic [DIM_BITS-1:0]        row_limit;
        logic                       busy;
    } t_cfg;

endpackage

@@ hw/rtl/rgtp_if.sv @@
`timescale 1ns / 1ps

// pixel coordinate channel
interface rgtp_pix_in_if #(
    parameter int COORD_BITS = rgtp_pkg::COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// pattern result channel
interface rgtp_pix_out_if ();
    logic                                valid;
    logic                                ready;
    logic [rgtp_pkg::COLOR_BITS-1:0]     pixel_color;
    logic                                inside_grid;
    logic [rgtp_pkg::ADDR_BITS-1:0]      byte_address;

    modport source (output valid, output pixel_color, output inside_grid,
                    output byte_address, input ready);
    modport sink   (input valid, input pixel_color, input inside_grid,
                    input byte_address, output ready);
endinterface

@@ hw/rtl/rect_grid_test_pattern_pixel.sv @@
`timescale 1ns / 1ps
// a coordinate passes the front register, queue, divider, m1, m2 and output registers
// throughput: one pixel per cycle unless stalled or busy; the column and row come
// from an 8-stage pipelined restoring divider, one quotient bit per stage
// reset (synchronous, active low) loads the register defaults, then the cell size
// is worked out by a bit-serial divider; a write to h_res, v_res or
// rect_count reruns it, and no coordinate is taken while it runs

module rect_grid_test_pattern_pixel #(
    parameter int COORD_BITS = rgtp_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rgtp_pix_in_if.sink                     i_pix,
    rgtp_pix_out_if.source                  o_pix,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rgtp_pkg::PADDR_BITS-1:0] paddr,
    input  logic [rgtp_pkg::PDATA_BITS-1:0] pwdata,
    output logic [rgtp_pkg::PDATA_BITS-1:0] prdata,
    output logic                            pready
);
    import rgtp_pkg::*;

    localparam int JOB_BITS = 2 * COORD_BITS + 1;

    t_cfg                w_cfg;
    logic                w_fq_valid;
    logic                w_fq_ready;
    logic [JOB_BITS-1:0] w_fq_job;
    logic                w_qb_valid;
    logic                w_qb_ready;
    logic [JOB_BITS-1:0] w_qb_job;

    // registers and grid geometry
    rgtp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // accept and classify
    rgtp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_cfg       (w_cfg),
        .o_job_valid (w_fq_valid),
        .i_job_ready (w_fq_ready),
        .o_job       (w_fq_job)
    );

    // decoupling queue
    rgtp_queue #(
        .WIDTH (JOB_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fq_valid),
        .o_ready (w_fq_ready),
        .i_data  (w_fq_job),
        .o_valid (w_qb_valid),
        .i_ready (w_qb_ready),
        .o_data  (w_qb_job)
    );

    // divide, color and address
    rgtp_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_qb_valid),
        .o_job_ready (w_qb_ready),
        .i_job       (w_qb_job),
        .i_cfg       (w_cfg),
        .o_pix       (o_pix)
    );

endmodule

@@ hw/rtl/rgtp_cfg.sv @@
`timescale 1ns / 1ps
`include "rect_grid_test_pattern_pixel_macros.svh"

module rgtp_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rgtp_pkg::PADDR_BITS-1:0] paddr,
    input  logic [rgtp_pkg::PDATA_BITS-1:0] pwdata,
    output logic [rgtp_pkg::PDATA_BITS-1:0] prdata,
    output logic                           pready,
    output rgtp_pkg::t_cfg                 o_cfg
);
    import rgtp_pkg::*;

    localparam int DIV_CNT_BITS = $clog2(DIM_BITS);
    localparam int NUM_LANES    = 2;

    logic                        w_wr;
    logic                        w_geo_wr;
    logic [REG_IDX_BITS-1:0]     w_idx;

    logic [DIM_BITS-1:0]         r_h_res;
    logic [DIM_BITS-1:0]         r_v_res;
    logic [CNT_BITS-1:0]         r_rect_count;
    logic [COLOR_BITS-1:0]       r_first_color;
    logic [COLOR_STEP_BITS-1:0]  r_color_step;
    logic                        r_direct_mode;
    logic [BPP_BITS-1:0]         r_bpp;
    logic [LAYOUT_BITS-1:0]      r_layout;

    // bit-serial divider state, lane 0 horizontal, lane 1 vertical
    logic                        r_busy;
    logic [DIV_CNT_BITS-1:0]     r_dstep;
    logic [CNT_BITS-1:0]         r_rem [NUM_LANES];
    logic [DIM_BITS-1:0]         r_quo [NUM_LANES];
    logic [CNT_BITS-1:0]         n_rem [NUM_LANES];
    logic [NUM_LANES-1:0]        w_ge;
    logic [DIM_BITS-1:0]         w_dvd [NUM_LANES];
    logic [CNT_BITS:0]           w_trial [NUM_LANES];
    logic [DIV_CNT_BITS-1:0]     w_bit_idx;

    assign pready   = 1'b1;
    assign w_wr     = psel && penable && pwrite;
    assign w_idx    = paddr[PADDR_BITS-1:2];
    assign w_geo_wr = w_wr && (w_idx inside {REG_H_RES, REG_V_RES, REG_RECT_COUNT});

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_res       <= H_RES_RST;
            r_v_res       <= V_RES_RST;
            r_rect_count  <= RECT_COUNT_RST;
            r_first_color <= FIRST_COLOR_RST;
            r_color_step  <= COLOR_STEP_RST;
            r_direct_mode <= DIRECT_MODE_RST;
            r_bpp         <= BPP_RST;
            r_layout      <= LAYOUT_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_H_RES:          r_h_res       <= pwdata[DIM_BITS-1:0];
                REG_V_RES:          r_v_res       <= pwdata[DIM_BITS-1:0];
                REG_RECT_COUNT:     r_rect_count  <= pwdata[CNT_BITS-1:0];
                REG_FIRST_COLOR:    r_first_color <= pwdata[COLOR_BITS-1:0];
                REG_COLOR_STEP:     r_color_step  <= pwdata[COLOR_STEP_BITS-1:0];
                REG_DIRECT_MODE:    r_direct_mode <= pwdata[0];
                REG_PIX_DEPTH:      r_bpp         <= pwdata[BPP_BITS-1:0];
                REG_CHANNEL_LAYOUT: r_layout      <= pwdata[LAYOUT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (w_idx)
            REG_H_RES:          prdata = PDATA_BITS'(r_h_res);
            REG_V_RES:          prdata = PDATA_BITS'(r_v_res);
            REG_RECT_COUNT:     prdata = PDATA_BITS'(r_rect_count);
            REG_FIRST_COLOR:    prdata = PDATA_BITS'(r_first_color);
            REG_COLOR_STEP:     prdata = PDATA_BITS'(r_color_step);
            REG_DIRECT_MODE:    prdata = PDATA_BITS'(r_direct_mode);
            REG_PIX_DEPTH:      prdata = PDATA_BITS'(r_bpp);
            REG_CHANNEL_LAYOUT: prdata = PDATA_BITS'(r_layout);
            default:            prdata = '0;
        endcase
    end

    // one quotient bit per cycle, msb first
    assign w_bit_idx = DIV_CNT_BITS'(DIM_BITS - 1) - r_dstep;
    assign w_dvd[0]  = r_h_res;
    assign w_dvd[1]  = r_v_res;

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            w_trial[l] = {r_rem[l], w_dvd[l][w_bit_idx]};
            w_ge[l]    = w_trial[l] >= {1'b0, r_rect_count};
            n_rem[l]   = w_ge[l] ? CNT_BITS'(w_trial[l] - {1'b0, r_rect_count})
                                 : w_trial[l][CNT_BITS-1:0];
        end
    end

    // restart on reset or any geometry write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_geo_wr) begin
            r_busy  <= 1'b1;
            r_dstep <= '0;
            for (int l = 0; l < NUM_LANES; l++) begin
                r_rem[l] <= '0;
                r_quo[l] <= '0;
            end
        end else if (r_busy) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                r_rem[l] <= n_rem[l];
                r_quo[l] <= {r_quo[l][DIM_BITS-2:0], w_ge[l]};
            end
            if (r_dstep == DIV_CNT_BITS'(DIM_BITS - 1)) begin
                r_busy <= 1'b0;
            end
            r_dstep <= r_dstep + 1'b1;
        end
    end

    // settings and geometry to the datapath
    always_comb begin
        o_cfg.h_res          = r_h_res;
        o_cfg.rect_count     = r_rect_count;
        o_cfg.first_color    = r_first_color;
        o_cfg.color_step     = r_color_step;
        o_cfg.direct_mode    = r_direct_mode;
        o_cfg.pix_depth      = r_bpp;
        o_cfg.channel_layout = r_layout;
        o_cfg.col_width      = r_quo[0];
        o_cfg.row_height     = r_quo[1];
        o_cfg.col_limit      = r_h_res - DIM_BITS'(r_rem[0]);
        o_cfg.row_limit      = r_v_res - DIM_BITS'(r_rem[1]);
        o_cfg.busy           = r_busy;
    end

    `RGTP_ASSERT_NEXT(a_geo_restart, i_clk, i_rst_n, w_geo_wr, r_busy && r_dstep == '0)

endmodule

@@ hw/rtl/rgtp_front.sv @@
`timescale 1ns / 1ps

module rgtp_front #(
    parameter int COORD_BITS = rgtp_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rgtp_pix_in_if.sink           i_pix,
    input  rgtp_pkg::t_cfg        i_cfg,
    output logic                  o_job_valid,
    input  logic                  i_job_ready,
    output logic [2*COORD_BITS:0] o_job
);
    import rgtp_pkg::*;

    localparam int LW = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  in_grid;
    } t_job;

    logic  r_vld;
    t_job  r_job;
    t_job  n_job;
    logic  w_take;

    // hold off while the grid geometry is being worked out
    assign i_pix.ready = !i_cfg.busy && (!r_vld || i_job_ready);
    assign w_take      = i_pix.valid && i_pix.ready;

    // inside the painted grid: below the last full column and row
    always_comb begin
        n_job.x       = i_pix.pixel_x;
        n_job.y       = i_pix.pixel_y;
        n_job.in_grid = (i_cfg.rect_count != '0)
                     && (LW'(i_pix.pixel_x) < LW'(i_cfg.col_limit))
                     && (LW'(i_pix.pixel_y) < LW'(i_cfg.row_limit));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_take) begin
            r_vld <= 1'b1;
        end else if (i_job_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_job <= n_job;
        end
    end

    assign o_job_valid = r_vld;
    assign o_job       = r_job;

endmodule

@@ hw/rtl/rgtp_queue.sv @@
`timescale 1ns / 1ps
`include "rect_grid_test_pattern_pixel_macros.svh"

module rgtp_queue #(
    parameter int WIDTH = 2 * rgtp_pkg::COORD_BITS_DEF + 1,
    parameter int DEPTH = rgtp_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_W-1:0]    r_count;
    logic                w_push;
    logic                w_pop;

    assign o_ready = r_count != CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // word storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `RGTP_ASSERT_NEXT(a_fill_up, i_clk, i_rst_n, w_push && !w_pop, r_count == $past(r_count) + 1'b1)

endmodule

@@ hw/rtl/rgtp_back.sv @@
`timescale 1ns / 1ps
`include "rect_grid_test_pattern_pixel_macros.svh"

module rgtp_back #(
    parameter int COORD_BITS = rgtp_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    output logic                  o_job_ready,
    input  logic [2*COORD_BITS:0] i_job,
    input  rgtp_pkg::t_cfg        i_cfg,
    rgtp_pix_out_if.source        o_pix
);
    import rgtp_pkg::*;

    localparam int NSTG      = CNT_BITS;
    localparam int CW        = (COORD_BITS > DIM_BITS + CNT_BITS - 1) ? COORD_BITS
                                                                      : DIM_BITS + CNT_BITS - 1;
    localparam int PROD_BITS = CNT_BITS + COLOR_STEP_BITS;
    localparam int IDX_BITS  = 2 * CNT_BITS;
    localparam int IP_BITS   = IDX_BITS + COLOR_STEP_BITS;
    localparam int YH_BITS   = COORD_BITS + DIM_BITS;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  in_grid;
    } t_job;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  in_grid;
        logic [COORD_BITS-1:0] rem_x;
        logic [COORD_BITS-1:0] rem_y;
        logic [CNT_BITS-1:0]   col;
        logic [CNT_BITS-1:0]   row;
    } t_div;

    typedef struct packed {
        logic                   in_grid;
        logic [PROD_BITS-1:0]   cstep;
        logic [PROD_BITS-1:0]   rstep;
        logic [PROD_BITS:0]     sstep;
        logic [IDX_BITS-1:0]    idx;
        logic [ADDR_BITS-1:0]   addr;
    } t_m1;

    typedef struct packed {
        logic                              in_grid;
        logic [NUM_CHAN-1:0][COLOR_BITS-1:0] chan;
        logic [COLOR_BITS-1:0]             icolor;
        logic [ADDR_BITS-1:0]              addr;
    } t_m2;

    typedef struct packed {
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  inside_grid;
        logic [ADDR_BITS-1:0]  byte_address;
    } t_out;

    logic             w_adv;
    t_job             w_job;
    t_div             w_src [NSTG];
    t_div             w_dout [NSTG];
    t_div             r_div [NSTG];
    logic [NSTG-1:0]  r_dv;
    t_m1              n_m1;
    t_m1              r_m1;
    logic             r_m1_vld;
    t_m2              n_m2;
    t_m2              r_m2;
    logic             r_m2_vld;
    t_out             n_out;
    t_out             r_out;
    logic             r_out_vld;

    // whole pipeline moves unless the output word is stuck
    assign w_adv       = !r_out_vld || o_pix.ready;
    assign o_job_ready = w_adv;
    assign w_job       = i_job;

    // restoring division, one column bit and one row bit per stage
    for (genvar k = 0; k < NSTG; k++) begin : g_div
        localparam int B = NSTG - 1 - k;
        logic [CW-1:0] w_dx;
        logic [CW-1:0] w_dy;
        logic          w_gx;
        logic          w_gy;

        // first stage starts with the coordinates as remainders
        if (k == 0) begin : g_head
            assign w_src[k] = '{x: w_job.x, y: w_job.y, in_grid: w_job.in_grid,
                                rem_x: w_job.x, rem_y: w_job.y, col: '0, row: '0};
        end else begin : g_link
            assign w_src[k] = r_div[k-1];
        end

        assign w_dx = CW'(i_cfg.col_width) << B;
        assign w_dy = CW'(i_cfg.row_height) << B;
        assign w_gx = CW'(w_src[k].rem_x) >= w_dx;
        assign w_gy = CW'(w_src[k].rem_y) >= w_dy;

        always_comb begin
            w_dout[k] = w_src[k];
            if (w_gx) begin
                w_dout[k].rem_x = COORD_BITS'(CW'(w_src[k].rem_x) - w_dx);
            end
            if (w_gy) begin
                w_dout[k].rem_y = COORD_BITS'(CW'(w_src[k].rem_y) - w_dy);
            end
            w_dout[k].col[B] = w_gx;
            w_dout[k].row[B] = w_gy;
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_div[k] <= w_dout[k];
            end
        end
    end

    // steps per channel, cell index and pixel address
    always_comb begin
        n_m1.in_grid = r_div[NSTG-1].in_grid;
        n_m1.cstep  = PROD_BITS'(r_div[NSTG-1].col) * PROD_BITS'(i_cfg.color_step);
        n_m1.rstep  = PROD_BITS'(r_div[NSTG-1].row) * PROD_BITS'(i_cfg.color_step);
        n_m1.sstep  = (PROD_BITS + 1)'((CNT_BITS + 1)'(r_div[NSTG-1].col)
                                      + (CNT_BITS + 1)'(r_div[NSTG-1].row))
                    * (PROD_BITS + 1)'(i_cfg.color_step);
        n_m1.idx    = IDX_BITS'(IDX_BITS'(r_div[NSTG-1].row) * IDX_BITS'(i_cfg.rect_count)
                              + IDX_BITS'(r_div[NSTG-1].col));
        n_m1.addr   = ADDR_BITS'(YH_BITS'(r_div[NSTG-1].y) * YH_BITS'(i_cfg.h_res)
                               + YH_BITS'(r_div[NSTG-1].x));
    end

    // channel add and wrap, indexed color, scale address by bytes per pixel
    always_comb begin
        logic [NUM_CHAN-1:0][COLOR_BITS-1:0] add;
        logic [FIELD_BITS-1:0]               size;
        logic [FIELD_BITS-1:0]               pos;
        logic [COLOR_BITS-1:0]               mask;
        logic [COLOR_BITS-1:0]               base;
        logic [IP_BITS-1:0]                  iprod;
        logic [BPB_BITS-1:0]                 bpb;

        add[0] = COLOR_BITS'(r_m1.cstep);
        add[1] = COLOR_BITS'(r_m1.rstep);
        add[2] = COLOR_BITS'(r_m1.sstep);
        for (int c = 0; c < NUM_CHAN; c++) begin
            size = i_cfg.channel_layout[FIELD_BITS*(2*c) +: FIELD_BITS];
            pos  = i_cfg.channel_layout[FIELD_BITS*(2*c+1) +: FIELD_BITS];
            mask = ~({COLOR_BITS{1'b1}} << size);
            base = (i_cfg.first_color >> pos) & mask;
            n_m2.chan[c] = (base + add[c]) & mask;
        end
        iprod = IP_BITS'(r_m1.idx) * IP_BITS'(i_cfg.color_step);
        n_m2.icolor = i_cfg.first_color + COLOR_BITS'(iprod);
        bpb = BPB_BITS'(((BPP_BITS + 1)'(i_cfg.pix_depth)
                        + (BPP_BITS + 1)'(BPB_ROUND)) >> BPB_SHIFT);
        n_m2.addr    = ADDR_BITS'(r_m1.addr * ADDR_BITS'(bpb));
        n_m2.in_grid = r_m1.in_grid;
    end

    // repack channels or wrap index color, black outside the grid
    always_comb begin
        logic [COLOR_BITS-1:0] dcol;
        logic [COLOR_BITS-1:0] icol;
        logic [FIELD_BITS-1:0] pos;

        dcol = '0;
        for (int c = 0; c < NUM_CHAN; c++) begin
            pos  = i_cfg.channel_layout[FIELD_BITS*(2*c+1) +: FIELD_BITS];
            dcol = dcol | (r_m2.chan[c] << pos);
        end
        if (i_cfg.pix_depth >= BPP_BITS'(COLOR_BITS)) begin
            icol = r_m2.icolor;
        end else begin
            icol = r_m2.icolor
                 & ~({COLOR_BITS{1'b1}} << i_cfg.pix_depth[FIELD_BITS-1:0]);
        end
        n_out.pixel_color  = !r_m2.in_grid ? '0 : (i_cfg.direct_mode ? dcol : icol);
        n_out.inside_grid  = r_m2.in_grid;
        n_out.byte_address = r_m2.addr;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m1  <= n_m1;
            r_m2  <= n_m2;
            r_out <= n_out;
        end
    end

    // valid bits along the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv      <= '0;
            r_m1_vld  <= 1'b0;
            r_m2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_dv      <= {r_dv[NSTG-2:0], i_job_valid};
            r_m1_vld  <= r_dv[NSTG-1];
            r_m2_vld  <= r_m1_vld;
            r_out_vld <= r_m2_vld;
        end
    end

    assign o_pix.valid        = r_out_vld;
    assign o_pix.pixel_color  = r_out.pixel_color;
    assign o_pix.inside_grid  = r_out.inside_grid;
    assign o_pix.byte_address = r_out.byte_address;

    `RGTP_ASSERT_SAME(a_outside_black, i_clk, i_rst_n, r_out_vld && !r_out.inside_grid, r_out.pixel_color == '0)
    `RGTP_ASSERT_NEXT(a_pipe_freeze, i_clk, i_rst_n, !w_adv && r_m2_vld, r_m2_vld && $stable(r_m2))
    `RGTP_ASSERT_NEXT(a_no_drop, i_clk, i_rst_n, r_m2_vld && w_adv, r_out_vld)

endmodule
